### hdl/kfm64_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 64-bit key featurizer.
// No dependencies; every other file imports this package.
package kfm64_pkg;

  localparam int KEY_LEN_W       = 16;
  localparam int DEF_LENGTH_BITS = 16;
  localparam int LEN_MAX_BITS    = 31;
  localparam int CQ_DEPTH        = 2;

  localparam logic [63:0] MIX_M      = 64'hc6a4a7935bd1e995;
  localparam int          MIX_R      = 47;
  localparam logic [31:0] SEED_RESET = 32'd588503011;

  // Largest decimal literal is 2^63-1: value / 10 and value % 10.
  localparam logic [62:0] LIT_LIMIT = 63'd922337203685477580;
  localparam logic [3:0]  LIT_LAST  = 4'd7;

  localparam logic [7:0] CHAR_MARK = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [1:0] KIND_EMPTY   = 2'd0;
  localparam logic [1:0] KIND_LITERAL = 2'd1;
  localparam logic [1:0] KIND_PACKED  = 2'd2;
  localparam logic [1:0] KIND_HASHED  = 2'd3;

  // Work for the back end: optional hash start, optional word mix, optional result.
  typedef struct packed {
    logic                    init;
    logic [LEN_MAX_BITS-1:0] len;
    logic                    mix;
    logic [63:0]             word;
    logic                    fin;
    logic [1:0]              kind;
    logic                    tail;
    logic [63:0]             data;
  } cmd_t;

endpackage

### hdl/kfm64_in_if.sv
`timescale 1ns / 1ps
// Key byte channel: valid/ready plus one key byte with length and last mark.
// Depends on kfm64_pkg.
interface kfm64_in_if import kfm64_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           key_byte;
  logic [KEY_LEN_W-1:0] key_length;
  logic                 last_byte;

  modport source (output valid, output key_byte, output key_length, output last_byte,
                  input ready);
  modport sink (input valid, input key_byte, input key_length, input last_byte,
                output ready);
endinterface

### hdl/kfm64_out_if.sv
`timescale 1ns / 1ps
// Feature channel: valid/ready plus the 64-bit feature and its kind.
// Depends on kfm64_pkg.
interface kfm64_out_if import kfm64_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [63:0] feature;
  logic [1:0]         feature_kind;

  modport source (output valid, output feature, output feature_kind, input ready);
  modport sink (input valid, input feature, input feature_kind, output ready);
endinterface

### hdl/kfm64_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus the hash seed.
// Depends on kfm64_pkg.
interface kfm64_cfg_if import kfm64_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] hash_seed;

  modport source (output valid, output hash_seed, input ready);
  modport sink (input valid, input hash_seed, output ready);
endinterface

### hdl/kfm64_front.sv
`timescale 1ns / 1ps
// Front end: takes key bytes, tracks the literal check and word packing,
// and issues back-end commands. Depends on kfm64_pkg, kfm64_in_if.
module kfm64_front import kfm64_pkg::*; #(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst,
  kfm64_in_if.sink   key_in,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  logic [LENGTH_BITS-1:0] byte_index;
  logic [63:0]            word_buf;
  logic [62:0]            literal_acc;
  logic                   literal_ok;
  logic                   leading_hash_mark;

  logic [LENGTH_BITS+KEY_LEN_W-1:0] wide_len;
  logic [LENGTH_BITS-1:0]           len;
  logic                             accept;
  logic                             len_zero;
  logic                             first;
  logic                             is_digit;
  logic [3:0]                       digit;
  logic                             fits;
  logic [62:0]                      lit_x10;
  logic                             lead_next;
  logic                             ok_next;
  logic [62:0]                      lacc_next;
  logic [63:0]                      wb_or;
  logic [LENGTH_BITS-1:0]           bi_next;
  logic                             mix;
  logic [63:0]                      wb_after;
  logic                             short_key;

  assign key_in.ready = cmd_ready;
  assign accept       = key_in.valid && key_in.ready;

  assign wide_len = {{LENGTH_BITS{1'b0}}, key_in.key_length};
  assign len      = wide_len[LENGTH_BITS-1:0];
  assign len_zero = (len == '0);
  assign first    = (byte_index == '0);
  assign is_digit = (key_in.key_byte >= CHAR_ZERO) && (key_in.key_byte <= CHAR_NINE);
  assign digit    = key_in.key_byte[3:0];
  assign fits     = (literal_acc < LIT_LIMIT) ||
                    ((literal_acc == LIT_LIMIT) && (digit <= LIT_LAST));
  assign lit_x10  = (literal_acc << 3) + (literal_acc << 1) + 63'(digit);

  always_comb begin
    lead_next = leading_hash_mark;
    ok_next   = literal_ok;
    lacc_next = literal_acc;
    if (first) begin
      lead_next = (key_in.key_byte == CHAR_MARK);
      ok_next   = 1'b0;
      lacc_next = '0;
    end else if (leading_hash_mark) begin
      if (is_digit && fits) begin
        lacc_next = lit_x10;
        ok_next   = 1'b1;
      end else begin
        lead_next = 1'b0;
        ok_next   = 1'b0;
      end
    end
  end

  assign wb_or     = word_buf | (64'(key_in.key_byte) << {byte_index[2:0], 3'b000});
  assign bi_next   = byte_index + 1'b1;
  assign mix       = (bi_next[2:0] == 3'd0);
  assign wb_after  = mix ? 64'd0 : wb_or;
  assign short_key = (bi_next[LENGTH_BITS-1:3] == '0);

  always_comb begin
    cmd      = '0;
    cmd.len  = LEN_MAX_BITS'(len);
    cmd.word = wb_or;
    if (len_zero) begin
      cmd.fin  = 1'b1;
      cmd.kind = KIND_EMPTY;
    end else begin
      cmd.init = first;
      cmd.mix  = mix;
      cmd.fin  = key_in.last_byte;
      if (lead_next && ok_next) begin
        cmd.kind = KIND_LITERAL;
        cmd.data = {1'b0, lacc_next};
      end else if (short_key) begin
        cmd.kind = KIND_PACKED;
        cmd.data = wb_after;
      end else begin
        cmd.kind = KIND_HASHED;
        cmd.data = wb_after;
        cmd.tail = (bi_next[2:0] != 3'd0);
      end
    end
  end

  assign cmd_valid = accept && (cmd.init || cmd.mix || cmd.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= '0;
      word_buf          <= '0;
      literal_acc       <= '0;
      literal_ok        <= 1'b0;
      leading_hash_mark <= 1'b0;
    end else if (accept) begin
      // empty key or end of key: drop everything for the next key
      if (len_zero || key_in.last_byte) begin
        byte_index        <= '0;
        word_buf          <= '0;
        literal_acc       <= '0;
        literal_ok        <= 1'b0;
        leading_hash_mark <= 1'b0;
      end else begin
        byte_index        <= bi_next;
        word_buf          <= wb_after;
        literal_acc       <= lacc_next;
        literal_ok        <= ok_next;
        leading_hash_mark <= lead_next;
      end
    end
  end

  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    accept && key_in.last_byte |=> (byte_index == '0) && !leading_hash_mark)
    else $error("front state not cleared after end of key");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_ready)
    else $error("command issued without queue room");

endmodule

### hdl/kfm64_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between front and back end, held in registers.
// Depends on kfm64_pkg (cmd_t, CQ_DEPTH).
module kfm64_cmd_fifo import kfm64_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop
);

  localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CQ_DEPTH + 1);

  cmd_t             entry [CQ_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(CQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CQ_DEPTH))
    else $error("command queue overfilled");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty command queue");

endmodule

### hdl/kfm64_back.sv
`timescale 1ns / 1ps
// Back end: runs hash start, word mixing and finalization on one shared
// 32x32 multiplier, holds the seed and the output register. Depends on kfm64_pkg.
module kfm64_back import kfm64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cq_cmd,
  input  logic        cq_valid,
  output logic        cq_pop,
  kfm64_cfg_if.sink   seed_cfg,
  kfm64_out_if.source feat_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_MIX1 = 4'd2;
  localparam logic [3:0] S_MIX2 = 4'd3;
  localparam logic [3:0] S_MIX3 = 4'd4;
  localparam logic [3:0] S_FIN0 = 4'd5;
  localparam logic [3:0] S_TAIL = 4'd6;
  localparam logic [3:0] S_FIN1 = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [1:0]  step;
  logic [63:0] mul_x;
  logic [63:0] mul_x_next;
  logic [63:0] mp;
  logic [63:0] acc;
  logic [63:0] h;
  logic [63:0] h_next;
  cmd_t        cmd;
  cmd_t        cmd_next;
  logic [63:0] res;
  logic [63:0] res_next;
  logic [1:0]  res_kind;
  logic [1:0]  res_kind_next;
  logic [31:0] seed;
  logic        ov;
  logic [63:0] feature;
  logic [1:0]  feature_kind;

  logic        in_mul;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] r;
  logic        load_out;

  assign seed_cfg.ready = 1'b1;

  assign in_mul = (state == S_INIT) || (state == S_MIX1) || (state == S_MIX2) ||
                  (state == S_MIX3) || (state == S_TAIL) || (state == S_FIN1);
  assign done   = in_mul && (step == 2'd3);
  // low 64 bits of x*M: lo*lo + ((lo*hi + hi*lo) << 32), one partial a cycle
  assign mul_a  = (step == 2'd2) ? mul_x[63:32] : mul_x[31:0];
  assign mul_b  = (step == 2'd1) ? MIX_M[63:32] : MIX_M[31:0];
  assign r      = acc + {mp[31:0], 32'd0};

  always_comb begin
    logic [63:0] fz;
    fz            = r ^ (r >> MIX_R);
    state_next    = state;
    mul_x_next    = mul_x;
    h_next        = h;
    cmd_next      = cmd;
    res_next      = res;
    res_kind_next = res_kind;
    cq_pop        = 1'b0;
    load_out      = 1'b0;
    case (state)
      S_IDLE: begin
        if (cq_valid) begin
          cq_pop   = 1'b1;
          cmd_next = cq_cmd;
          if (cq_cmd.init) begin
            state_next = S_INIT;
            mul_x_next = 64'(cq_cmd.len);
          end else if (cq_cmd.mix) begin
            state_next = S_MIX1;
            mul_x_next = cq_cmd.word;
          end else begin
            state_next = S_FIN0;
          end
        end
      end
      S_INIT: begin
        if (done) begin
          h_next = {32'd0, seed} ^ r;
          if (cmd.mix) begin
            state_next = S_MIX1;
            mul_x_next = cmd.word;
          end else begin
            state_next = S_FIN0;
          end
        end
      end
      S_MIX1: begin
        if (done) begin
          mul_x_next = fz;
          state_next = S_MIX2;
        end
      end
      S_MIX2: begin
        if (done) begin
          h_next     = h ^ r;
          mul_x_next = h ^ r;
          state_next = S_MIX3;
        end
      end
      S_MIX3: begin
        if (done) begin
          h_next     = r;
          state_next = S_FIN0;
        end
      end
      S_FIN0: begin
        if (!cmd.fin) begin
          state_next = S_IDLE;
        end else if (cmd.kind != KIND_HASHED) begin
          res_next      = cmd.data;
          res_kind_next = cmd.kind;
          state_next    = S_OUT;
        end else if (cmd.tail) begin
          mul_x_next = h ^ cmd.data;
          state_next = S_TAIL;
        end else begin
          mul_x_next = h ^ (h >> MIX_R);
          state_next = S_FIN1;
        end
      end
      S_TAIL: begin
        if (done) begin
          mul_x_next = fz;
          state_next = S_FIN1;
        end
      end
      S_FIN1: begin
        if (done) begin
          // make positive, wrapping for the most negative value, then tag
          if ((fz == 64'd0) || fz[63]) begin
            fz = 64'd0 - fz;
          end
          res_next      = fz | (64'd1 << 56);
          res_kind_next = KIND_HASHED;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov || feat_out.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
      seed  <= SEED_RESET;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= in_mul ? step + 2'd1 : 2'd0;
      if (seed_cfg.valid) begin
        seed <= seed_cfg.hash_seed;
      end
      if (load_out) begin
        ov <= 1'b1;
      end else if (feat_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_x    <= mul_x_next;
    h        <= h_next;
    cmd      <= cmd_next;
    res      <= res_next;
    res_kind <= res_kind_next;
    mp       <= mul_a * mul_b;
    if (step == 2'd1) begin
      acc <= mp;
    end else if (step == 2'd2) begin
      acc <= r;
    end
    if (load_out) begin
      feature      <= res;
      feature_kind <= res_kind;
    end
  end

  assign feat_out.valid        = ov;
  assign feat_out.feature      = feature;
  assign feat_out.feature_kind = feature_kind;

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    in_mul && (step != 2'd3) |=> step == $past(step) + 2'd1)
    else $error("multiplier step sequence broken");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (step != 2'd0) |-> in_mul)
    else $error("multiplier step running outside a multiply");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> (state == S_IDLE) && cq_valid)
    else $error("command taken while busy");

endmodule

### hdl/key_featurizer_murmur64_core.sv
`timescale 1ns / 1ps
// Key featurizer top level: front end, command queue, back end.
// Depends on kfm64_pkg, the channel interfaces and the three submodules.
//
// One key byte is taken per cycle while the two-entry command queue has room.
// The back end does all 64-bit multiplies by the mixing constant on one
// 32x32 multiplier, from partial products: starting a key takes one
// multiply, mixing each full 8-byte word three, and finishing a hashed key
// one or two, after which the result is loaded into the output register.
// Empty, literal and packed keys need no finishing multiply; a last byte
// that also starts the key adds the start multiply, one that closes a word
// adds the word mix. The seed may be written at any idle time and applies
// from the next key start.
module key_featurizer_murmur64_core import kfm64_pkg::*; #(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input logic         clk,
  input logic         rst,
  kfm64_in_if.sink    key_in,
  kfm64_cfg_if.sink   seed_cfg,
  kfm64_out_if.source feat_out
);

  cmd_t fe_cmd;
  logic fe_valid;
  logic cq_ready;
  cmd_t cq_cmd;
  logic cq_valid;
  logic cq_pop;

  kfm64_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_in),
    .cmd       (fe_cmd),
    .cmd_valid (fe_valid),
    .cmd_ready (cq_ready)
  );

  kfm64_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (fe_cmd),
    .push       (fe_valid),
    .push_ready (cq_ready),
    .pop_cmd    (cq_cmd),
    .pop_valid  (cq_valid),
    .pop        (cq_pop)
  );

  kfm64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_cmd   (cq_cmd),
    .cq_valid (cq_valid),
    .cq_pop   (cq_pop),
    .seed_cfg (seed_cfg),
    .feat_out (feat_out)
  );

endmodule
